// ===== src/sle_pkg.sv =====
package sle_pkg;

   // Default buffer depth
   localparam int MAX_LINE_DEF = 64;

   localparam logic [6:0] LIMIT_RESET = 7'd64;

   // Terminal characters
   localparam logic [7:0] CH_XON   = 8'h11;
   localparam logic [7:0] CH_XOFF  = 8'h13;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [1:0] {
      KIND_ECHO = 2'd0,
      KIND_LINE = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ECHO_NONE  = 2'd0,
      ECHO_ONE   = 2'd1,
      ECHO_THREE = 2'd2
   } echo_cls_type;

   typedef enum logic [2:0] {
      SEL_BS    = 3'd0,
      SEL_SPACE = 3'd1,
      SEL_CHAR  = 3'd2,
      SEL_LINE  = 3'd3,
      SEL_END   = 3'd4
   } out_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_DECIDE = 3'd1,
      ST_ECHO   = 3'd2,
      ST_BS1    = 3'd3,
      ST_BS2    = 3'd4,
      ST_BS3    = 3'd5,
      ST_LINE   = 3'd6,
      ST_END    = 3'd7
   } state_type;

   typedef struct packed {
      logic        accept;
      logic        out_load;
      out_sel_type out_sel;
      logic        out_last;
      logic        rd_first;
      logic        rd_next;
      logic        clr_count;
   } cmd_type;

   typedef struct packed {
      logic         out_free;
      echo_cls_type echo_cls;
      logic         done;
      logic         line_nonempty;
      logic         line_last;
   } status_type;

endpackage

// ===== src/sle_ctrl.sv =====
module sle_ctrl import sle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.accept    = 1'b0;
      cmd.out_load  = 1'b0;
      cmd.out_sel   = SEL_CHAR;
      cmd.out_last  = 1'b0;
      cmd.rd_first  = 1'b0;
      cmd.rd_next   = 1'b0;
      cmd.clr_count = 1'b0;
      req_stall     = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            case (sts.echo_cls)
               ECHO_ONE:   state_in = ST_ECHO;
               ECHO_THREE: state_in = ST_BS1;
               default: begin
                  if (!sts.done) begin
                     state_in = ST_IDLE;
                  end else if (sts.line_nonempty) begin
                     cmd.rd_first = 1'b1;
                     state_in     = ST_LINE;
                  end else begin
                     state_in = ST_END;
                  end
               end
            endcase
         end
         ST_ECHO, ST_BS3: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = (state_ff == ST_ECHO) ? SEL_CHAR : SEL_BS;
               cmd.out_last = !sts.done;
               if (!sts.done) begin
                  state_in = ST_IDLE;
               end else if (sts.line_nonempty) begin
                  cmd.rd_first = 1'b1;
                  state_in     = ST_LINE;
               end else begin
                  state_in = ST_END;
               end
            end
         end
         ST_BS1: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_BS;
               state_in     = ST_BS2;
            end
         end
         ST_BS2: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_SPACE;
               state_in     = ST_BS3;
            end
         end
         ST_LINE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_LINE;
               if (sts.line_last) begin
                  state_in = ST_END;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         ST_END: begin
            if (sts.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_sel   = SEL_END;
               cmd.out_last  = 1'b1;
               cmd.clr_count = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/sle_datapath.sv =====
module sle_datapath import sle_pkg::*; #(
   parameter int MAX_LINE = MAX_LINE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_in_byte,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic       rsp_last_of_run,
   input  cmd_type    cmd,
   output status_type sts
);

   localparam int CNT_W  = $clog2(MAX_LINE + 1);
   localparam int ADDR_W = $clog2(MAX_LINE);
   localparam int CMP_W  = CNT_W + 8;

   logic [6:0]        limit_ff;
   logic [CNT_W-1:0]  count_ff, count_in, count_new;
   logic [7:0]        char_ff;
   logic              done_ff;
   echo_cls_type      echo_ff, echo_new;
   logic [ADDR_W-1:0] idx_ff, rd_addr;
   logic [7:0]        rd_data_ff;
   logic [7:0]        line_mem [MAX_LINE];

   logic [7:0]        char_map;
   logic              is_bs, is_ign, store_en, done_new;
   logic [CMP_W-1:0]  lim_ext, lim_eff;

   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   // Input decode; CR is handled as LF
   always_comb begin
      char_map = (req_in_byte == CH_CR) ? CH_LF : req_in_byte;
      is_bs    = (char_map == CH_BS) || (char_map == CH_DEL);
      is_ign   = (char_map == CH_XON) || (char_map == CH_XOFF);
      store_en = !is_bs && !is_ign && (count_ff < CNT_W'(MAX_LINE));

      if (is_bs && (count_ff != '0)) begin
         count_new = count_ff - CNT_W'(1);
      end else if (store_en) begin
         count_new = count_ff + CNT_W'(1);
      end else begin
         count_new = count_ff;
      end

      if (is_bs) begin
         echo_new = (count_ff != '0) ? ECHO_THREE : ECHO_NONE;
      end else if (is_ign) begin
         echo_new = ECHO_NONE;
      end else begin
         echo_new = ECHO_ONE;
      end

      // Limit clamped to 2 .. MAX_LINE
      lim_ext = CMP_W'(limit_ff);
      if (lim_ext < CMP_W'(2)) begin
         lim_eff = CMP_W'(2);
      end else if (lim_ext > CMP_W'(MAX_LINE)) begin
         lim_eff = CMP_W'(MAX_LINE);
      end else begin
         lim_eff = lim_ext;
      end
      done_new = (CMP_W'(count_new) + CMP_W'(1) >= lim_eff) || (char_map == CH_LF);

      if (cmd.clr_count) begin
         count_in = '0;
      end else if (cmd.accept) begin
         count_in = count_new;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         count_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         char_ff <= char_map;
         done_ff <= done_new;
         echo_ff <= echo_new;
      end
   end

   // Line store: one write on accept, one registered read
   assign rd_addr = cmd.rd_first ? '0 : (idx_ff + ADDR_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.accept && store_en) begin
         line_mem[count_ff[ADDR_W-1:0]] <= char_map;
      end
      if (cmd.rd_first || cmd.rd_next) begin
         idx_ff     <= rd_addr;
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.out_last;
         case (cmd.out_sel)
            SEL_BS: begin
               rsp_kind_in = KIND_ECHO;
               rsp_data_in = CH_BS;
            end
            SEL_SPACE: begin
               rsp_kind_in = KIND_ECHO;
               rsp_data_in = CH_SPACE;
            end
            SEL_CHAR: begin
               rsp_kind_in = KIND_ECHO;
               rsp_data_in = char_ff;
            end
            SEL_LINE: begin
               rsp_kind_in = KIND_LINE;
               rsp_data_in = rd_data_ff;
            end
            SEL_END: begin
               rsp_kind_in = KIND_END;
               rsp_data_in = 8'h00;
            end
            default: begin
               rsp_kind_in = KIND_END;
               rsp_data_in = 8'h00;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_data        = rsp_data_ff;
   assign rsp_last_of_run = rsp_last_ff;

   assign sts.out_free      = !rsp_valid_ff || !rsp_stall;
   assign sts.echo_cls      = echo_ff;
   assign sts.done          = done_ff;
   assign sts.line_nonempty = (count_ff > CNT_W'(1));
   assign sts.line_last     = (CMP_W'(idx_ff) + CMP_W'(2) == CMP_W'(count_ff));

   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("output register overwritten while stalled");

   a_read_in_line : assert property (@(posedge clock) disable iff (reset)
      cmd.rd_next |-> (CMP_W'(idx_ff) + CMP_W'(2) < CMP_W'(count_ff)))
      else $error("line read beyond stored bytes");

   a_first_read : assert property (@(posedge clock) disable iff (reset)
      cmd.rd_first |-> (count_ff > CNT_W'(1)))
      else $error("line walk started with no bytes to emit");

   a_count_cleared : assert property (@(posedge clock) disable iff (reset)
      cmd.clr_count |=> (count_ff == '0))
      else $error("count not cleared after line end");

endmodule

// ===== src/serial_line_editor_top.sv =====
// Terminal line editor with backspace echo.
// req_ channel: one received byte per transfer (req_in_byte). req_stall is
//   low only while the editor is idle; it rises for the whole of one byte's
//   processing, so bytes are taken one at a time.
// rsp_ channel: echo bytes (kind 0), completed line bytes (kind 1) and one
//   line-end item (kind 2, data zero); rsp_last_of_run marks the final item
//   a byte causes. XON/XOFF can only end a line; empty-line rubouts do nothing.
// csr_: csr_wr_en writes csr_wr_data into the line limit (reset 64); write
//   only while idle. Limits below 2 act as 2, above MAX_LINE as MAX_LINE.
// A byte holds the input until its last result is loaded. Worst case is
//   64 results (echo, 62 line bytes, line end at a limit of 64). The line
//   store has a single read port and walks one byte a cycle while the
//   receiver does not stall.
// Reset (synchronous, active high): count cleared, limit back to 64,
//   output empty. The line store is not cleared.
// A stalled receiver holds the output register; the controller waits and
//   nothing is lost or reordered. req_stall drops in the cycle after the
//   previous byte's last result is loaded into the output register.
module serial_line_editor_top import sle_pkg::*; #(
   parameter int MAX_LINE = MAX_LINE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic       rsp_last_of_run
);

   cmd_type    cmd;
   status_type sts;

   // Sequencer: decode, echo, line walk, line end
   sle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Count, limit, line store and output register
   sle_datapath #(
      .MAX_LINE (MAX_LINE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_in_byte     (req_in_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_data        (rsp_data),
      .rsp_last_of_run (rsp_last_of_run),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule

// ===== verif/serial_line_editor_top_test.sv =====
`timescale 1ns / 100ps

module serial_line_editor_top_test;
   import sle_pkg::*;

   localparam int LINE_MAX = MAX_LINE_DEF;
   localparam int IDX_W    = $clog2(LINE_MAX);
   // Long enough for a full line walk to finish, with margin on top.
   localparam int SETTLE_CYCLES = 80;
   // Worst case is far below this even with every result stalled at length.
   localparam int CYCLE_LIMIT = 400000;

   // One result transfer as seen on the rsp_ channel.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } rsp_item_type;

   // One row of the directed plan: either a limit write or a received byte.
   // Where fixed is set, the expected results are spelt out in the row and
   // the predictor only tracks state.
   typedef struct packed {
      logic                  is_limit;
      logic [7:0]            value;
      logic                  fixed;
      logic [1:0]            n_fix;
      rsp_item_type [2:0]    fix;
   } plan_row_type;

   localparam rsp_item_type NO_RSP = '0;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       csr_wr_en   = 1'b0;
   logic [6:0] csr_wr_data = 7'd0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data;
   logic       rsp_last_of_run;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int fail_count    = 0;
   int cycle_count   = 0;

   // Predictor's own copy of the editor state and the limit register.
   logic [6:0]  line_limit_q = LIMIT_RESET;
   int unsigned stored_count = 0;
   logic [7:0]  stored_bytes [LINE_MAX];

   rsp_item_type step_results [$];   // results of the byte just taken
   rsp_item_type pending_rsp  [$];   // results still owed by the editor
   plan_row_type directed_plan [$];

   serial_line_editor_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_data        (rsp_data),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: random stall, and every result transfer is checked against
   // the oldest outstanding expectation. Values read here are those that
   // held at the edge, since everything is driven with nonblocking writes.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("result with nothing expected: kind %0d data %0h last %0b",
                   rsp_kind, rsp_data, rsp_last_of_run);
            fail_count++;
         end else begin
            rsp_item_type want;
            want = pending_rsp.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               fail_count++;
            end
            if (rsp_data !== want.data) begin
               $error("data: expected %0h, got %0h", want.data, rsp_data);
               fail_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0b, got %0b", want.last,
                      rsp_last_of_run);
               fail_count++;
            end
         end
      end
   end

   function automatic rsp_item_type rsp(kind_type k, logic [7:0] d, logic l);
      rsp_item_type r;
      r.kind = k;
      r.data = d;
      r.last = l;
      return r;
   endfunction

   function automatic void add_result(kind_type k, logic [7:0] d);
      step_results.push_back(rsp(k, d, 1'b0));
   endfunction

   // Line editor predictor: updates the stored line and fills step_results
   // with everything one received byte causes.
   function automatic void line_edit(input logic [7:0] rx);
      logic [7:0]   ch;
      int unsigned  eff_limit;
      rsp_item_type tail;
      step_results.delete();
      ch = (rx == CH_CR) ? CH_LF : rx;
      // Out-of-range limits are clamped into 2..LINE_MAX
      if (line_limit_q < 2)
         eff_limit = 2;
      else if (line_limit_q > LINE_MAX)
         eff_limit = LINE_MAX;
      else
         eff_limit = 32'(line_limit_q);

      if (ch == CH_BS || ch == CH_DEL) begin
         // rubout on an empty line is silent
         if (stored_count != 0) begin
            stored_count--;
            add_result(KIND_ECHO, CH_BS);
            add_result(KIND_ECHO, CH_SPACE);
            add_result(KIND_ECHO, CH_BS);
         end
      end else if (ch != CH_XON && ch != CH_XOFF) begin
         if (stored_count < LINE_MAX) begin
            stored_bytes[IDX_W'(stored_count)] = ch;
            stored_count++;
         end
         add_result(KIND_ECHO, ch);
      end

      // Completion test runs after every byte, ignored ones included.
      if (stored_count >= eff_limit - 1 || ch == CH_LF) begin
         for (int i = 0; i + 1 < stored_count; i++)
            add_result(KIND_LINE, stored_bytes[IDX_W'(i)]);
         add_result(KIND_END, 8'h00);
         stored_count = 0;
      end

      if (step_results.size() > 0) begin
         tail = step_results.pop_back();
         tail.last = 1'b1;
         step_results.push_back(tail);
      end
   endfunction

   // Mostly typed text with rubouts and line ends; some raw noise bytes.
   function automatic logic [7:0] typed_byte(int eol_pct);
      int pick;
      pick = $urandom_range(99);
      if (pick < eol_pct)
         return $urandom_range(1) ? CH_CR : CH_LF;
      if (pick < eol_pct + 6)
         return $urandom_range(1) ? CH_BS : CH_DEL;
      if (pick < eol_pct + 8)
         return $urandom_range(1) ? CH_XON : CH_XOFF;
      if (pick < eol_pct + 14)
         return 8'($urandom_range(255));
      return 8'($urandom_range(126, 32));
   endfunction

   function automatic plan_row_type row_limit(logic [6:0] v);
      plan_row_type r;
      r          = '0;
      r.is_limit = 1'b1;
      r.value    = {1'b0, v};
      return r;
   endfunction

   function automatic plan_row_type row_pred(logic [7:0] b);
      plan_row_type r;
      r       = '0;
      r.value = b;
      return r;
   endfunction

   function automatic plan_row_type row_fix(logic [7:0] b, logic [1:0] n,
                                            rsp_item_type r0, rsp_item_type r1,
                                            rsp_item_type r2);
      plan_row_type r;
      r        = '0;
      r.value  = b;
      r.fixed  = 1'b1;
      r.n_fix  = n;
      r.fix[0] = r0;
      r.fix[1] = r1;
      r.fix[2] = r2;
      return r;
   endfunction

   // Sender: optional idle gap, then hold the byte until the transfer.
   // req_valid is left high on return so a back-to-back byte can follow in
   // the same step; every caller either sends again or lowers it at once.
   task automatic send_byte(input logic [7:0] rx, input logic use_fixed,
                            input logic [1:0] n_fix,
                            input rsp_item_type [2:0] fix);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_in_byte <= rx;
      do @(posedge clock); while (req_stall);
      line_edit(rx);
      if (use_fixed) begin
         for (int i = 0; i < n_fix; i++)
            pending_rsp.push_back(fix[2'(i)]);
      end else begin
         foreach (step_results[i])
            pending_rsp.push_back(step_results[i]);
      end
   endtask

   // Hold off the sender until every owed result has arrived. Always waits for
   // a clock edge so req_valid is never lowered and raised in one step.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   // Limit writes only with the editor idle: results drained, then enough
   // cycles for a byte that caused nothing to finish.
   task automatic write_limit(input logic [6:0] v);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      line_limit_q  = v;
   endtask

   initial begin
      int         items;
      int         eol_pct;
      logic [6:0] lim;

      // Directed plan. Starts on the reset limit of 64.
      // Rubout and flow-control bytes on an empty line: nothing comes back.
      directed_plan.push_back(row_fix(CH_BS,   2'd0, NO_RSP, NO_RSP, NO_RSP));
      directed_plan.push_back(row_fix(CH_DEL,  2'd0, NO_RSP, NO_RSP, NO_RSP));
      directed_plan.push_back(row_fix(CH_XON,  2'd0, NO_RSP, NO_RSP, NO_RSP));
      directed_plan.push_back(row_fix(CH_XOFF, 2'd0, NO_RSP, NO_RSP, NO_RSP));
      // Byte extremes are stored and echoed.
      directed_plan.push_back(row_fix(8'h00, 2'd1, rsp(KIND_ECHO, 8'h00, 1'b1),
                                      NO_RSP, NO_RSP));
      directed_plan.push_back(row_fix(8'hFF, 2'd1, rsp(KIND_ECHO, 8'hFF, 1'b1),
                                      NO_RSP, NO_RSP));
      // Rubout on a non-empty line: BS, space, BS.
      directed_plan.push_back(row_fix(CH_DEL, 2'd3, rsp(KIND_ECHO, CH_BS, 1'b0),
                                      rsp(KIND_ECHO, CH_SPACE, 1'b0),
                                      rsp(KIND_ECHO, CH_BS, 1'b1)));
      directed_plan.push_back(row_fix(8'h41, 2'd1, rsp(KIND_ECHO, 8'h41, 1'b1),
                                      NO_RSP, NO_RSP));
      // CR turns into LF and closes the line.
      directed_plan.push_back(row_pred(CH_CR));
      // LF on an empty line: its echo, then a bare line end.
      directed_plan.push_back(row_fix(CH_LF, 2'd2, rsp(KIND_ECHO, CH_LF, 1'b0),
                                      rsp(KIND_END, 8'h00, 1'b1), NO_RSP));
      // Limit below range acts as 2: every stored byte completes a line.
      directed_plan.push_back(row_limit(7'd0));
      directed_plan.push_back(row_fix(8'h55, 2'd2, rsp(KIND_ECHO, 8'h55, 1'b0),
                                      rsp(KIND_END, 8'h00, 1'b1), NO_RSP));
      directed_plan.push_back(row_fix(CH_XON, 2'd0, NO_RSP, NO_RSP, NO_RSP));
      directed_plan.push_back(row_limit(7'd1));
      directed_plan.push_back(row_pred(8'h80));
      // Limit above range acts as the buffer size.
      directed_plan.push_back(row_limit(7'd127));
      directed_plan.push_back(row_pred("a"));
      directed_plan.push_back(row_pred("b"));
      directed_plan.push_back(row_pred("c"));
      // Limit lowered mid-line: an ignored byte completes it.
      directed_plan.push_back(row_limit(7'd3));
      directed_plan.push_back(row_pred(CH_XOFF));
      directed_plan.push_back(row_pred("x"));
      directed_plan.push_back(row_pred("y"));
      // Limit lowered mid-line: a rubout echoes first, then completes.
      directed_plan.push_back(row_limit(7'd64));
      directed_plan.push_back(row_pred("p"));
      directed_plan.push_back(row_pred("q"));
      directed_plan.push_back(row_pred("r"));
      directed_plan.push_back(row_pred("s"));
      directed_plan.push_back(row_limit(7'd3));
      directed_plan.push_back(row_pred(CH_BS));
      directed_plan.push_back(row_limit(7'd65));
      directed_plan.push_back(row_pred(8'h7E));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_limit)
            write_limit(directed_plan[i].value[6:0]);
         else
            send_byte(directed_plan[i].value, directed_plan[i].fixed,
                      directed_plan[i].n_fix, directed_plan[i].fix);
      end

      // Random part, one phase per idling pattern.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               // no idling; full-size lines, line ends only from noise
               send_idle_pct = 0;
               stall_pct     = 0;
               lim           = 7'd64;
               items         = 80;
               eol_pct       = 0;
            end
            1: begin
               send_idle_pct = 57;
               stall_pct     = 0;
               lim           = 7'($urandom_range(12, 2));
               items         = 20;
               eol_pct       = 8;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 57;
               lim           = 7'($urandom_range(127));
               items         = 20;
               eol_pct       = 6;
            end
            default: begin
               send_idle_pct = 7;
               stall_pct     = 7;
               lim           = 7'($urandom_range(8, 2));
               items         = 20;
               eol_pct       = 8;
            end
         endcase
         write_limit(lim);
         for (int n = 0; n < items; n++) begin
            // mid-phase the sender waits for every owed result
            if (n == items / 2)
               drain_results();
            send_byte(typed_byte(eol_pct), 1'b0, 2'd0, '0);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
